// ----- rtl/uvs_pkg.sv -----
// uvs_pkg: shared types, constants and the CORDIC arctangent table for the
// UV-sphere vertex generator. No dependencies.
package uvs_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int MAX_DIVISIONS_DEF = 1024;
   localparam int ATAN_ENTRIES      = 24;
   localparam int IDX_W             = 11;
   localparam int CSR_W             = 16;
   localparam int CSR_IDX_W         = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RINGS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENTS = 2'd2;

   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [23:0] ONE_Q15 = 24'sd32768;

   typedef struct packed {
      logic [10:0] ring_index;
      logic [10:0] segment_index;
   } req_type;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic signed [23:0] tan_x;
      logic signed [23:0] tan_z;
      logic signed [31:0] bit_x;
      logic signed [31:0] bit_y;
      logic signed [31:0] bit_z;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic               pole_flag;
   } rsp_type;

   function automatic logic signed [33:0] atan_turn(input int i);
      logic signed [33:0] t;
      unique case (i)
         0: t = 34'sd536870912;   1: t = 34'sd316933406;
         2: t = 34'sd167458907;   3: t = 34'sd85004756;
         4: t = 34'sd42667331;    5: t = 34'sd21354465;
         6: t = 34'sd10679838;    7: t = 34'sd5340245;
         8: t = 34'sd2670163;     9: t = 34'sd1335087;
         10: t = 34'sd667544;     11: t = 34'sd333772;
         12: t = 34'sd166886;     13: t = 34'sd83443;
         14: t = 34'sd41722;      15: t = 34'sd20861;
         16: t = 34'sd10430;      17: t = 34'sd5215;
         18: t = 34'sd2608;       19: t = 34'sd1304;
         20: t = 34'sd652;        21: t = 34'sd326;
         22: t = 34'sd163;        23: t = 34'sd81;
         default: t = 34'sd0;
      endcase
      return t;
   endfunction

endpackage

// ----- rtl/uv_sphere_vertex_generator.sv -----
// uv_sphere_vertex_generator: top level; clamps indices, divides, runs the
// CORDIC and forms the vertex. Uses uvs_pkg, uvs_divider, uvs_cordic.
//
// One vertex request is taken every clock (busy is always low). Its result
// appears with rsp_valid after the input register, one divider stage per
// quotient bit (43 bits with defaults), the CORDIC angle register and its
// rotation stages, four product stages and the output register. Results cannot
// be stalled, so the receiver must take each one in the cycle it shows.
module uv_sphere_vertex_generator #(
   parameter int CORDIC_STAGES = uvs_pkg::CORDIC_STAGES_DEF,
   parameter int MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  uvs_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output uvs_pkg::rsp_type               rsp_data,
   input  logic                           csr_write,
   input  logic [uvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [uvs_pkg::CSR_W-1:0]      csr_data
);
   import uvs_pkg::*;

   localparam int CW    = $clog2(MAX_DIVISIONS + 1);
   localparam int NUM_W = 32 + CW;
   localparam int NS    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
   localparam int SIDE_W = 2 * CW + 2 * CW + 16 + 2;
   // counts never exceed the index range, so a larger limit acts as the top of that range
   localparam int MAXD_I = (MAX_DIVISIONS > (1 << IDX_W) - 1) ? (1 << IDX_W) - 1
                                                               : MAX_DIVISIONS;
   localparam logic [IDX_W-1:0] MAXD = IDX_W'(MAXD_I);

   logic [15:0]      radius_ff;
   logic [IDX_W-1:0] rings_ff, segs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         rings_ff  <= 11'd20;
         segs_ff   <= 11'd20;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RADIUS:   radius_ff <= csr_data;
            CSR_RINGS:    rings_ff  <= csr_data[IDX_W-1:0];
            CSR_SEGMENTS: segs_ff   <= csr_data[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // clamp stage
   logic [IDX_W-1:0] stacks_in, slices_in, ring_in, seg_in;
   always_comb begin
      stacks_in = (rings_ff < 11'd2) ? 11'd2 : ((rings_ff > MAXD) ? MAXD : rings_ff);
      slices_in = (segs_ff < 11'd3) ? 11'd3 : ((segs_ff > MAXD) ? MAXD : segs_ff);
      ring_in   = (req_data.ring_index > stacks_in) ? stacks_in : req_data.ring_index;
      seg_in    = (req_data.segment_index > slices_in) ? slices_in : req_data.segment_index;
   end

   logic             v0_ff;
   logic [CW-1:0]    ring0_ff, seg0_ff, stacks0_ff, slices0_ff;
   logic [15:0]      rad0_ff;
   logic             pole0_ff, south0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= start;
      ring0_ff   <= CW'(ring_in);
      seg0_ff    <= CW'(seg_in);
      stacks0_ff <= CW'(stacks_in);
      slices0_ff <= CW'(slices_in);
      rad0_ff    <= radius_ff;
      pole0_ff   <= (ring_in == 11'd0) || (ring_in == stacks_in);
      south0_ff  <= (ring_in != 11'd0);
   end

   // phi = ring*2^31/stacks, theta = seg*2^32/slices, u,v = (idx*2^17+den)/(2 den)
   logic [NUM_W-1:0] phi_num, th_num, u_num, v_num;
   logic [NUM_W-1:0] phi_q, th_q, u_q, v_q;
   logic [CW:0]      den2_u, den2_v;
   logic             dv_valid;
   logic [SIDE_W-1:0] side_in, side_out, side_u, side_v, side_t;
   logic dummy_u, dummy_v, dummy_t;

   always_comb begin
      phi_num = NUM_W'(ring0_ff) << 31;
      th_num  = NUM_W'(seg0_ff) << 32;
      u_num   = (NUM_W'(seg0_ff) << 17) + NUM_W'(slices0_ff);
      v_num   = (NUM_W'(ring0_ff) << 17) + NUM_W'(stacks0_ff);
      den2_u  = {slices0_ff, 1'b0};
      den2_v  = {stacks0_ff, 1'b0};
      side_in = {ring0_ff, seg0_ff, stacks0_ff, slices0_ff, rad0_ff, pole0_ff, south0_ff};
   end

   uvs_divider #(.NUM_W(NUM_W), .DEN_W(CW), .SIDE_W(SIDE_W)) u_div_phi (
      .clock, .reset, .in_valid(v0_ff), .in_num(phi_num), .in_den(stacks0_ff),
      .in_side(side_in), .out_valid(dv_valid), .out_quot(phi_q), .out_side(side_out));
   uvs_divider #(.NUM_W(NUM_W), .DEN_W(CW), .SIDE_W(SIDE_W)) u_div_th (
      .clock, .reset, .in_valid(v0_ff), .in_num(th_num), .in_den(slices0_ff),
      .in_side(side_in), .out_valid(dummy_t), .out_quot(th_q), .out_side(side_t));
   uvs_divider #(.NUM_W(NUM_W), .DEN_W(CW+1), .SIDE_W(SIDE_W)) u_div_u (
      .clock, .reset, .in_valid(v0_ff), .in_num(u_num), .in_den(den2_u),
      .in_side(side_in), .out_valid(dummy_u), .out_quot(u_q), .out_side(side_u));
   uvs_divider #(.NUM_W(NUM_W), .DEN_W(CW+1), .SIDE_W(SIDE_W)) u_div_v (
      .clock, .reset, .in_valid(v0_ff), .in_num(v_num), .in_den(den2_v),
      .in_side(side_in), .out_valid(dummy_v), .out_quot(v_q), .out_side(side_v));

   logic signed [33:0] sp, cp, st, ct;
   uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cor_phi (
      .clock, .in_angle(phi_q[31:0]), .out_sin(sp), .out_cos(cp));
   uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cor_th (
      .clock, .in_angle(th_q[31:0]), .out_sin(st), .out_cos(ct));

   // delay line alongside the CORDIC
   localparam int DL = NS + 1;
   logic        dl_v_ff    [DL+1];
   logic [15:0] dl_rad_ff  [DL+1];
   logic        dl_pole_ff [DL+1];
   logic        dl_south_ff[DL+1];
   logic [16:0] dl_u_ff    [DL+1];
   logic [16:0] dl_v17_ff  [DL+1];
   always_comb begin
      dl_v_ff[0]     = dv_valid & ~(dummy_t ^ dv_valid) & ~(dummy_u ^ dv_valid)
                       & ~(dummy_v ^ dv_valid);
      dl_rad_ff[0]   = side_out[17:2];
      dl_pole_ff[0]  = side_out[1] & side_t[1] & side_u[1] & side_v[1] | side_out[1];
      dl_south_ff[0] = side_out[0];
      dl_u_ff[0]     = u_q[16:0];
      dl_v17_ff[0]   = v_q[16:0];
   end
   for (genvar d = 0; d < DL; d++) begin : g_dl
      always_ff @(posedge clock) begin
         if (reset) dl_v_ff[d+1] <= 1'b0;
         else dl_v_ff[d+1] <= dl_v_ff[d];
         dl_rad_ff[d+1]   <= dl_rad_ff[d];
         dl_pole_ff[d+1]  <= dl_pole_ff[d];
         dl_south_ff[d+1] <= dl_south_ff[d];
         dl_u_ff[d+1]     <= dl_u_ff[d];
         dl_v17_ff[d+1]   <= dl_v17_ff[d];
      end
   end

   // product stage A: r*sin phi, r*cos phi
   logic               a_v_ff, a_pole_ff, a_south_ff;
   logic [15:0]        a_rad_ff;
   logic [16:0]        a_u_ff, a_v17_ff;
   logic signed [50:0] a_rsp_ff, a_rcp_ff;
   logic signed [33:0] a_st_ff, a_ct_ff;
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else a_v_ff <= dl_v_ff[DL];
      a_pole_ff  <= dl_pole_ff[DL];
      a_south_ff <= dl_south_ff[DL];
      a_rad_ff   <= dl_rad_ff[DL];
      a_u_ff     <= dl_u_ff[DL];
      a_v17_ff   <= dl_v17_ff[DL];
      a_rsp_ff   <= $signed({1'b0, dl_rad_ff[DL]}) * sp;
      a_rcp_ff   <= $signed({1'b0, dl_rad_ff[DL]}) * cp;
      a_st_ff    <= st;
      a_ct_ff    <= ct;
   end

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      logic signed [23:0] r;
      if (v > 64'sd8388607) r = 24'sd8388607;
      else if (v < -64'sd8388608) r = -24'sd8388608;
      else r = v[23:0];
      return r;
   endfunction
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // stage B: rs, py; products rs*ct, rs*st
   logic signed [50:0] rs_b;
   logic signed [50:0] py_full;
   always_comb begin
      rs_b    = (a_rsp_ff + 51'sd4194304) >>> 23;
      py_full = (a_rcp_ff + 51'sd4194304) >>> 23;
   end
   logic               b_v_ff, b_pole_ff, b_south_ff;
   logic [15:0]        b_rad_ff;
   logic [16:0]        b_u_ff, b_v17_ff;
   logic signed [63:0] b_px_ff, b_pz_ff;
   logic signed [23:0] b_py_ff;
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else b_v_ff <= a_v_ff;
      b_pole_ff  <= a_pole_ff;
      b_south_ff <= a_south_ff;
      b_rad_ff   <= a_rad_ff;
      b_u_ff     <= a_u_ff;
      b_v17_ff   <= a_v17_ff;
      // rs is signed and fits in 26 bits for any radius
      b_px_ff    <= $signed(rs_b[25:0]) * a_ct_ff;
      b_pz_ff    <= $signed(rs_b[25:0]) * a_st_ff;
      b_py_ff    <= sat24(64'(py_full));
   end

   // stage C: round position; tangent follows
   logic signed [23:0] px_c, pz_c, tx_c;
   always_comb begin
      px_c = sat24((b_px_ff + 64'sd536870912) >>> 30);
      pz_c = sat24((b_pz_ff + 64'sd536870912) >>> 30);
      tx_c = sat24(-64'(pz_c));
   end
   logic               c_v_ff, c_pole_ff, c_south_ff;
   logic [15:0]        c_rad_ff;
   logic [16:0]        c_u_ff, c_v17_ff;
   logic signed [23:0] c_px_ff, c_py_ff, c_pz_ff, c_tx_ff;
   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else c_v_ff <= b_v_ff;
      c_pole_ff  <= b_pole_ff;
      c_south_ff <= b_south_ff;
      c_rad_ff   <= b_rad_ff;
      c_u_ff     <= b_u_ff;
      c_v17_ff   <= b_v17_ff;
      c_px_ff    <= px_c;
      c_py_ff    <= b_py_ff;
      c_pz_ff    <= pz_c;
      c_tx_ff    <= tx_c;
   end

   // stage D: cross-product terms
   logic               d_v_ff, d_pole_ff, d_south_ff;
   logic [15:0]        d_rad_ff;
   logic [16:0]        d_u_ff, d_v17_ff;
   logic signed [23:0] d_px_ff, d_py_ff, d_pz_ff, d_tx_ff;
   logic signed [47:0] d_bx_ff, d_zx_ff, d_xz_ff, d_bz_ff;
   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else d_v_ff <= c_v_ff;
      d_pole_ff  <= c_pole_ff;
      d_south_ff <= c_south_ff;
      d_rad_ff   <= c_rad_ff;
      d_u_ff     <= c_u_ff;
      d_v17_ff   <= c_v17_ff;
      d_px_ff    <= c_px_ff;
      d_py_ff    <= c_py_ff;
      d_pz_ff    <= c_pz_ff;
      d_tx_ff    <= c_tx_ff;
      d_bx_ff    <= c_py_ff * c_px_ff;
      d_zx_ff    <= c_pz_ff * c_tx_ff;
      d_xz_ff    <= c_px_ff * c_px_ff;
      d_bz_ff    <= c_py_ff * c_tx_ff;
   end

   // output stage
   logic signed [63:0] by_e, bz_e, r128;
   rsp_type            out_in;
   always_comb begin
      by_e = 64'(d_zx_ff) - 64'(d_xz_ff);
      bz_e = -64'(d_bz_ff);
      r128 = {41'd0, d_rad_ff, 7'd0};
      if (d_pole_ff) begin
         out_in.pos_x = '0;
         out_in.pos_z = '0;
         out_in.pos_y = d_south_ff ? -r128[23:0] : r128[23:0];
         out_in.tan_x = ONE_Q15;
         out_in.tan_z = '0;
         out_in.bit_x = '0;
         out_in.bit_y = '0;
         out_in.bit_z = 32'(ONE_Q15);
         out_in.tex_u = '0;
         out_in.tex_v = d_south_ff ? 17'd65536 : 17'd0;
         out_in.pole_flag = 1'b1;
      end else begin
         out_in.pos_x = d_px_ff;
         out_in.pos_y = d_py_ff;
         out_in.pos_z = d_pz_ff;
         out_in.tan_x = d_tx_ff;
         out_in.tan_z = d_px_ff;
         out_in.bit_x = sat32((64'(d_bx_ff) + 64'sd16384) >>> 15);
         out_in.bit_y = sat32((by_e + 64'sd16384) >>> 15);
         out_in.bit_z = sat32((bz_e + 64'sd16384) >>> 15);
         out_in.tex_u = d_u_ff;
         out_in.tex_v = d_v17_ff;
         out_in.pole_flag = 1'b0;
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= d_v_ff;
      rsp_data_ff <= out_in;
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ----- rtl/uvs_divider.sv -----
// uvs_divider: pipelined restoring divider, one quotient bit per stage,
// with a sideband that travels alongside. Uses uvs_pkg.
module uvs_divider #(
   parameter int NUM_W  = 43,
   parameter int DEN_W  = 11,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);
   import uvs_pkg::*;

   logic              vld_ff  [NUM_W+1];
   logic [NUM_W-1:0]  num_ff  [NUM_W+1];
   logic [DEN_W:0]    rem_ff  [NUM_W+1];
   logic [DEN_W-1:0]  den_ff  [NUM_W+1];
   logic [SIDE_W-1:0] side_ff [NUM_W+1];

   always_comb begin
      vld_ff[0]  = in_valid;
      num_ff[0]  = in_num;
      rem_ff[0]  = '0;
      den_ff[0]  = in_den;
      side_ff[0] = in_side;
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [DEN_W+1:0] trial_in;
      logic [DEN_W+1:0] diff_in;
      always_comb begin
         trial_in = {rem_ff[s], num_ff[s][NUM_W-1]};
         diff_in  = trial_in - {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_ff[s];
         end
         den_ff[s+1]  <= den_ff[s];
         side_ff[s+1] <= side_ff[s];
         if (!diff_in[DEN_W+1]) begin
            rem_ff[s+1] <= diff_in[DEN_W:0];
            num_ff[s+1] <= {num_ff[s][NUM_W-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= trial_in[DEN_W:0];
            num_ff[s+1] <= {num_ff[s][NUM_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[NUM_W];
   assign out_quot  = num_ff[NUM_W];
   assign out_side  = side_ff[NUM_W];
endmodule

// ----- rtl/uvs_cordic.sv -----
// uvs_cordic: pipelined rotation-mode CORDIC giving sine and cosine (Q1.30)
// of a 32-bit turn fraction, one stage per register. Uses uvs_pkg.
module uvs_cordic #(
   parameter int STAGES = uvs_pkg::CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic [31:0]        in_angle,
   output logic signed [33:0] out_sin,
   output logic signed [33:0] out_cos
);
   import uvs_pkg::*;

   localparam int NS = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

   logic signed [33:0] x_ff [NS+1];
   logic signed [33:0] y_ff [NS+1];
   logic signed [33:0] z_ff [NS+1];
   logic               flip_ff [NS+1];

   logic        flip_in;
   logic [31:0] fold_in;
   logic [31:0] sum_in;

   always_comb begin
      sum_in  = in_angle + 32'h4000_0000;
      flip_in = sum_in[31];
      fold_in = flip_in ? (in_angle + 32'h8000_0000) : in_angle;
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= CORDIC_GAIN_Q30;
      y_ff[0]    <= '0;
      z_ff[0]    <= {{2{fold_in[31]}}, fold_in};
      flip_ff[0] <= flip_in;
   end

   for (genvar i = 0; i < NS; i++) begin : g_rot
      always_ff @(posedge clock) begin
         flip_ff[i+1] <= flip_ff[i];
         if (!z_ff[i][33]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_turn(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_turn(i);
         end
      end
   end

   assign out_sin = flip_ff[NS] ? -y_ff[NS] : y_ff[NS];
   assign out_cos = flip_ff[NS] ? -x_ff[NS] : x_ff[NS];
endmodule
